FILE: rtl/core/tfsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfsf_pkg
// Shared constants and fixed-point register defaults for the stencil force unit.
// ----------------------------------------------------------------------------
package tfsf_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NREG           = 5;
    localparam int REG_IDX_W      = 3;
    localparam int CFG_W          = 32;

    localparam logic [REG_IDX_W-1:0] REG_MU     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KAPPA  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MASS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LAMBDA = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INVDX  = 3'd4;

    localparam logic signed [CFG_W-1:0] RST_MU     = -32'sd1310720;
    localparam logic signed [CFG_W-1:0] RST_KAPPA  = 32'sd1310720;
    localparam logic signed [CFG_W-1:0] RST_MASS   = 32'sd65536;
    localparam logic signed [CFG_W-1:0] RST_LAMBDA = 32'sd0;
    localparam logic signed [CFG_W-1:0] RST_INVDX  = 32'sd660641;

    localparam int IN_TDATA_W  = 296;
    localparam int OUT_TDATA_W = 32;
endpackage
`default_nettype wire

FILE: rtl/core/tfsf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfsf_mul
// Registered fixed-point multiply: round half away from zero, saturate.
// ----------------------------------------------------------------------------
module tfsf_mul #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [DW-1:0] a,
    input  wire logic signed [DW-1:0] b,
    output logic signed [DW-1:0]      p_reg,
    output logic                      c_reg
);
    localparam int PW = 2 * DW + 1;
    logic signed [PW-1:0] prod;
    logic        [PW-1:0] m, r;
    logic        [PW-1:0] lim;
    logic                 neg;
    logic signed [DW-1:0] p_next;
    logic                 c_next;

    // Form magnitude, round, shift, and clamp
    always_comb begin
        prod = PW'(a) * PW'(b);
        neg  = prod[PW-1];
        m    = neg ? PW'(-prod) : PW'(prod);
        r    = (m + (PW'(1) << (FB - 1))) >> FB;
        lim  = (PW'(1) << (DW - 1)) - PW'(neg ? 0 : 1);
        if (r > lim) begin
            c_next = 1'b1;
            p_next = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            c_next = 1'b0;
            p_next = neg ? DW'(-r) : DW'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
            c_reg <= c_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/tfsf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfsf_div
// Pipelined restoring divider: round(n * 2^FB / d), half away from zero,
// saturated. Each stage resolves STEP quotient bits.
// ----------------------------------------------------------------------------
module tfsf_div #(
    parameter int DW   = 32,
    parameter int FB   = 16,
    parameter int STEP = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [DW-1:0] n,
    input  wire logic signed [DW-1:0] d,
    output logic signed [DW-1:0]      q,
    output logic                      c
);
    localparam int QW = DW + FB;
    localparam int NS = (QW + STEP - 1) / STEP;
    localparam int TB = NS * STEP;
    localparam int RW = DW + 1;

    logic [TB-1:0] dv_reg [NS+1];
    logic [TB-1:0] qt_reg [NS+1];
    logic [RW-1:0] rm_reg [NS+1];
    logic [DW-1:0] md_reg [NS+1];
    logic          ng_reg [NS+1];
    logic          dz_reg [NS+1];
    logic          nz_reg [NS+1];

    logic [DW-1:0] mn, mdv;

    always_comb begin
        mn  = n[DW-1] ? DW'(-n) : DW'(n);
        mdv = d[DW-1] ? DW'(-d) : DW'(d);
    end

    // Load the first stage
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg[0] <= TB'({mn, {FB{1'b0}}});
            qt_reg[0] <= '0;
            rm_reg[0] <= '0;
            md_reg[0] <= mdv;
            ng_reg[0] <= n[DW-1] ^ d[DW-1];
            dz_reg[0] <= (d == '0);
            nz_reg[0] <= (n == '0);
        end
    end

    // Advance STEP quotient bits per stage
    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [RW-1:0] rr;
        logic [TB-1:0] dd, qq;
        always_comb begin
            rr = rm_reg[s];
            dd = dv_reg[s];
            qq = qt_reg[s];
            for (int k = 0; k < STEP; k++) begin
                rr = {rr[RW-2:0], dd[TB-1]};
                dd = {dd[TB-2:0], 1'b0};
                if (rr >= RW'(md_reg[s])) begin
                    rr = rr - RW'(md_reg[s]);
                    qq = {qq[TB-2:0], 1'b1};
                end else begin
                    qq = {qq[TB-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rm_reg[s+1] <= rr;
                dv_reg[s+1] <= dd;
                qt_reg[s+1] <= qq;
                md_reg[s+1] <= md_reg[s];
                ng_reg[s+1] <= ng_reg[s];
                dz_reg[s+1] <= dz_reg[s];
                nz_reg[s+1] <= nz_reg[s];
            end
        end
    end

    // Round and clamp
    logic [TB:0]   qr;
    logic [TB:0]   lim;
    logic [RW-1:0] rem;
    always_comb begin
        rem = rm_reg[NS];
        qr  = {1'b0, qt_reg[NS]};
        if (rem >= RW'(md_reg[NS]) - rem) qr = qr + 1'b1;
        lim = (TB+1)'(1) << (DW - 1);
        if (!ng_reg[NS]) lim = lim - 1'b1;
        c = 1'b0;
        if (dz_reg[NS]) begin
            c = !nz_reg[NS];
            q = nz_reg[NS] ? '0 : (ng_reg[NS] ? {1'b1, {(DW-1){1'b0}}}
                                              : {1'b0, {(DW-1){1'b1}}});
        end else if (qr > lim) begin
            c = 1'b1;
            q = ng_reg[NS] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            q = ng_reg[NS] ? DW'(-qr) : DW'(qr);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/triple_field_stencil_force_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triple_field_stencil_force_unit
// Seven-point stencil force for three coupled fields, Q fixed point.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_      | in  | tdata: component..prev_z, tuser: at_edge
// m_      | out | tdata: accel, tuser: clipped
// cfg     | in  | cfg_we, cfg_idx, cfg_data
//
// One point enters per cycle unless the output stalls. The path from the input
// transfer to the result runs through seven multiply/add stages, the divider pipeline
// (a load stage plus one stage per four quotient bits, thirteen in all), two
// combine stages and the output register. The whole pipe advances when the
// output register is empty or being taken; a stall freezes every stage.
// Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module triple_field_stencil_force_unit
    import tfsf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // component[1:0], centre_first..third, next_x, prev_x, next_y, prev_y,
    // next_z, prev_z (32 bits each), zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // at_edge
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // accel
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // clipped
    output logic                        m_tuser,
    input  wire logic                   cfg_we,
    input  wire logic [REG_IDX_W-1:0]   cfg_idx,
    input  wire logic [CFG_W-1:0]       cfg_data
);
    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    // stages outside the divider: seven ahead of it, two combine stages after
    localparam int NSTG = 9;
    localparam int DIVL = ((DW + FB + 3) / 4) + 1;
    localparam int TOT = NSTG + DIVL;

    typedef logic signed [DW-1:0] d_t;
    localparam d_t MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam d_t MINV = {1'b1, {(DW-1){1'b0}}};

    // Clamp a 64-bit signed value to DW bits
    function automatic logic [DW:0] clamp64(input logic signed [63:0] v);
        logic signed [63:0] hi, lo;
        hi = 64'(MAXV);
        lo = 64'(MINV);
        if (v > hi) clamp64 = {1'b1, MAXV};
        else if (v < lo) clamp64 = {1'b1, MINV};
        else clamp64 = {1'b0, DW'(v)};
    endfunction

    // Clamped value without the flag
    function automatic d_t clampv(input logic signed [63:0] v);
        logic [DW:0] r;
        r = clamp64(v);
        clampv = r[DW-1:0];
    endfunction

    function automatic logic [DW:0] sadd(input d_t a, input d_t b);
        sadd = clamp64(64'(a) + 64'(b));
    endfunction

    function automatic logic [DW:0] ssub(input d_t a, input d_t b);
        ssub = clamp64(64'(a) - 64'(b));
    endfunction

    // Configuration registers
    d_t mu_reg, ka_reg, ms_reg, la_reg, ix_reg;
    logic [DW:0] cfg_cl;
    always_comb begin
        if (cfg_idx == REG_MU || cfg_idx == REG_LAMBDA)
            cfg_cl = clamp64(64'($signed(cfg_data)));
        else
            cfg_cl = clamp64($signed({33'd0, cfg_data[30:0]}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg <= clampv(64'(RST_MU));
            ka_reg <= clampv(64'(RST_KAPPA));
            ms_reg <= clampv(64'(RST_MASS));
            la_reg <= clampv(64'(RST_LAMBDA));
            ix_reg <= clampv(64'(RST_INVDX));
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_MU:     mu_reg <= cfg_cl[DW-1:0];
                REG_KAPPA:  ka_reg <= cfg_cl[DW-1:0];
                REG_MASS:   ms_reg <= cfg_cl[DW-1:0];
                REG_LAMBDA: la_reg <= cfg_cl[DW-1:0];
                REG_INVDX:  ix_reg <= cfg_cl[DW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic en;
    logic [TOT-1:0] v_reg;
    logic [TOT-1:0] e_reg;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[TOT-2:0], s_tvalid};
        end
    end
    always_ff @(posedge aclk) begin
        if (en) e_reg <= {e_reg[TOT-2:0], s_tuser};
    end

    // Stage 0: clamp inputs, select component
    d_t f_in [9];
    logic ic;
    logic [DW:0] t;
    logic [1:0] comp;
    always_comb begin
        ic = 1'b0;
        for (int i = 0; i < 9; i++) begin
            t = clamp64(64'($signed(s_tdata[2+32*i +: 32])));
            f_in[i] = t[DW-1:0];
            ic = ic | t[DW];
        end
        comp = s_tdata[1:0];
        if (comp == 2'd3) comp = 2'd2;
    end

    d_t p0_1, p1_1, p2_1, ctr_1, oa_1, ob_1, nb_1 [6];
    logic c_1;
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_1 <= f_in[0];
            p1_1 <= f_in[1];
            p2_1 <= f_in[2];
            ctr_1 <= f_in[comp];
            oa_1 <= (comp == 2'd0) ? f_in[1] : f_in[0];
            ob_1 <= (comp == 2'd2) ? f_in[1] : f_in[2];
            for (int i = 0; i < 6; i++) nb_1[i] <= f_in[3+i];
            c_1 <= ic;
        end
    end

    // Stage 1: neighbour partial sums, c2, products p01, dP, mass, pair sum
    logic [DW:0] a01, c2;
    always_comb begin
        a01 = sadd(nb_1[0], nb_1[1]);
    end
    d_t s01_2, n2_2, n3_2, n4_2, n5_2, c2_2, p2_2, ctr_2, ps_2;
    logic c_2, ps_c2;
    logic [DW:0] psum;
    always_comb begin
        c2 = sadd(ctr_1, ctr_1);
        psum = sadd(oa_1, ob_1);
    end
    d_t p01_2, dp_2, ms_2;
    logic p01c, dpc, msc;
    tfsf_mul #(.DW(DW), .FB(FB)) u_m01 (.aclk, .en, .a(p0_1), .b(p1_1),
        .p_reg(p01_2), .c_reg(p01c));
    tfsf_mul #(.DW(DW), .FB(FB)) u_mdp (.aclk, .en, .a(oa_1), .b(ob_1),
        .p_reg(dp_2), .c_reg(dpc));
    tfsf_mul #(.DW(DW), .FB(FB)) u_mms (.aclk, .en, .a(ms_reg), .b(ctr_1),
        .p_reg(ms_2), .c_reg(msc));
    always_ff @(posedge aclk) begin
        if (en) begin
            s01_2 <= a01[DW-1:0];
            n2_2 <= nb_1[2]; n3_2 <= nb_1[3]; n4_2 <= nb_1[4]; n5_2 <= nb_1[5];
            c2_2 <= c2[DW-1:0];
            p2_2 <= p2_1;
            ps_2 <= psum[DW-1:0];
            ps_c2 <= psum[DW] & (la_reg != '0);
            c_2 <= c_1 | a01[DW] | c2[DW];
        end
    end

    // Stage 2: serial neighbour sum continues, c4, P, pair product
    logic [DW:0] s3, c4;
    always_comb begin
        s3 = sadd(s01_2, n2_2);
        c4 = sadd(c2_2, c2_2);
    end
    d_t s3_3, n3_3, n4_3, n5_3, c2_3, c4_3, dp_3, ms_3;
    logic c_3;
    d_t P_3, pw_3;
    logic Pc, pwc;
    tfsf_mul #(.DW(DW), .FB(FB)) u_mP (.aclk, .en, .a(p01_2), .b(p2_2),
        .p_reg(P_3), .c_reg(Pc));
    tfsf_mul #(.DW(DW), .FB(FB)) u_mpw (.aclk, .en, .a(la_reg), .b(ps_2),
        .p_reg(pw_3), .c_reg(pwc));
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_3 <= s3[DW-1:0];
            n3_3 <= n3_2; n4_3 <= n4_2; n5_3 <= n5_2;
            c2_3 <= c2_2; c4_3 <= c4[DW-1:0];
            dp_3 <= dp_2; ms_3 <= ms_2;
            c_3 <= c_2 | s3[DW] | c4[DW] | p01c | dpc | msc | ps_c2;
        end
    end
    logic lz;
    assign lz = (la_reg == '0);

    // Stage 3: sum, c6, P*P, mu*P
    logic [DW:0] s4, c6;
    always_comb begin
        s4 = sadd(s3_3, n3_3);
        c6 = sadd(c4_3, c2_3);
    end
    d_t s4_4, n4_4, n5_4, c6_4, dp_4, ms_4, pw_4;
    logic c_4;
    d_t PP_4, muP_4;
    logic PPc, muPc;
    tfsf_mul #(.DW(DW), .FB(FB)) u_mPP (.aclk, .en, .a(P_3), .b(P_3),
        .p_reg(PP_4), .c_reg(PPc));
    tfsf_mul #(.DW(DW), .FB(FB)) u_mmu (.aclk, .en, .a(mu_reg), .b(P_3),
        .p_reg(muP_4), .c_reg(muPc));
    always_ff @(posedge aclk) begin
        if (en) begin
            s4_4 <= s4[DW-1:0];
            n4_4 <= n4_3; n5_4 <= n5_3;
            c6_4 <= c6[DW-1:0];
            dp_4 <= dp_3; ms_4 <= ms_3;
            pw_4 <= lz ? '0 : pw_3;
            c_4 <= c_3 | s4[DW] | c6[DW] | Pc | (pwc & !lz);
        end
    end

    // Stage 4: sum, kappa*PP, num
    logic [DW:0] s5;
    always_comb s5 = sadd(s4_4, n4_4);
    d_t s5_5, n5_5, c6_5, ms_5, pw_5;
    logic c_5;
    d_t kp_5, num_5;
    logic kpc, numc;
    tfsf_mul #(.DW(DW), .FB(FB)) u_mka (.aclk, .en, .a(ka_reg), .b(PP_4),
        .p_reg(kp_5), .c_reg(kpc));
    tfsf_mul #(.DW(DW), .FB(FB)) u_mnu (.aclk, .en, .a(muP_4), .b(dp_4),
        .p_reg(num_5), .c_reg(numc));
    always_ff @(posedge aclk) begin
        if (en) begin
            s5_5 <= s5[DW-1:0];
            n5_5 <= n5_4;
            c6_5 <= c6_4; ms_5 <= ms_4; pw_5 <= pw_4;
            c_5 <= c_4 | s5[DW] | PPc | muPc;
        end
    end

    // Stage 5: final neighbour sum, den = one + kp
    localparam logic [63:0] ONE64 = 64'd1 << FB;
    logic [DW:0] s6, one_c, dn;
    always_comb begin
        s6 = sadd(s5_5, n5_5);
        one_c = clamp64($signed(ONE64));
        dn = sadd(one_c[DW-1:0], kp_5);
    end
    d_t s6_6, c6_6, ms_6, pw_6, dn_6, num_6;
    logic c_6;
    always_ff @(posedge aclk) begin
        if (en) begin
            s6_6 <= s6[DW-1:0];
            c6_6 <= c6_5; ms_6 <= ms_5; pw_6 <= pw_5;
            dn_6 <= dn[DW-1:0]; num_6 <= num_5;
            c_6 <= c_5 | s6[DW] | one_c[DW] | dn[DW] | kpc | numc;
        end
    end

    // Stage 6: s - c6, den squared
    logic [DW:0] df;
    always_comb df = ssub(s6_6, c6_6);
    d_t df_7, ms_7, pw_7, num_7;
    logic c_7;
    d_t dd_7;
    logic ddc;
    tfsf_mul #(.DW(DW), .FB(FB)) u_mdd (.aclk, .en, .a(dn_6), .b(dn_6),
        .p_reg(dd_7), .c_reg(ddc));
    always_ff @(posedge aclk) begin
        if (en) begin
            df_7 <= df[DW-1:0];
            ms_7 <= ms_6; pw_7 <= pw_6; num_7 <= num_6;
            c_7 <= c_6 | df[DW];
        end
    end

    // Stage 7: laplacian times 1/dx^2; launch divider
    d_t lp_8;
    logic lpc;
    tfsf_mul #(.DW(DW), .FB(FB)) u_mlp (.aclk, .en, .a(df_7), .b(ix_reg),
        .p_reg(lp_8), .c_reg(lpc));
    d_t tq;
    logic tqc;
    tfsf_div #(.DW(DW), .FB(FB), .STEP(4)) u_div (.aclk, .en, .n(num_7),
        .d(dd_7), .q(tq), .c(tqc));

    // Delay laplacian side to meet the divider output
    localparam int DL = DIVL - 1;
    d_t lpd_reg [DL];
    d_t msd_reg [DL];
    d_t pwd_reg [DL];
    logic cd_reg [DL];
    d_t ms_8, pw_8;
    logic c_8;
    always_ff @(posedge aclk) begin
        if (en) begin
            ms_8 <= ms_7; pw_8 <= pw_7; c_8 <= c_7 | ddc;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            lpd_reg[0] <= lp_8;
            msd_reg[0] <= ms_8;
            pwd_reg[0] <= pw_8;
            cd_reg[0] <= c_8 | lpc;
            for (int k = 1; k < DL; k++) begin
                lpd_reg[k] <= lpd_reg[k-1];
                msd_reg[k] <= msd_reg[k-1];
                pwd_reg[k] <= pwd_reg[k-1];
                cd_reg[k] <= cd_reg[k-1];
            end
        end
    end

    // Combine: lap - mass
    logic [DW:0] a1;
    always_comb a1 = ssub(lpd_reg[DL-1], msd_reg[DL-1]);
    d_t a1_r, tq_r, pw_r;
    logic c_r;
    always_ff @(posedge aclk) begin
        if (en) begin
            a1_r <= a1[DW-1:0]; tq_r <= tq; pw_r <= pwd_reg[DL-1];
            c_r <= cd_reg[DL-1] | a1[DW] | tqc;
        end
    end

    // minus triple, minus pair
    logic [DW:0] a2;
    always_comb a2 = ssub(a1_r, tq_r);
    d_t a2_r, pw_r2;
    logic c_r2;
    always_ff @(posedge aclk) begin
        if (en) begin
            a2_r <= a2[DW-1:0]; pw_r2 <= pw_r; c_r2 <= c_r | a2[DW];
        end
    end

    logic [DW:0] a3;
    logic signed [63:0] w;
    logic [31:0] acc;
    logic oc;
    always_comb begin
        a3 = ssub(a2_r, pw_r2);
        w = 64'(signed'(a3[DW-1:0]));
        oc = a3[DW];
        if (w > 64'sd2147483647) begin
            acc = 32'h7FFFFFFF; oc = 1'b1;
        end else if (w < -64'sd2147483648) begin
            acc = 32'h80000000; oc = 1'b1;
        end else begin
            acc = w[31:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= v_reg[TOT-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= e_reg[TOT-1] ? '0 : acc;
            m_tuser <= e_reg[TOT-1] ? 1'b0 : (c_r2 | oc);
        end
    end
endmodule
`default_nettype wire
